// ----- src/fect_pkg.sv -----
// Package: shared types and constants of the filtered event count table
`default_nettype none
package fect_pkg;

  localparam int unsigned BANK_ENTRIES = 1024;
  localparam int unsigned SLOT_COUNT   = 256;

  localparam int unsigned SLOT_AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned IDXW    = (BANK_ENTRIES > 1) ? $clog2(BANK_ENTRIES) : 1;
  localparam int unsigned FILLW   = $clog2(BANK_ENTRIES + 1);
  localparam int unsigned EAW     = $clog2(2 * BANK_ENTRIES);

  localparam logic [31:0] ALL_CLUSTERS = 32'hFFFF_FFFF;
  localparam logic [31:0] TYPE_DDR = 32'd0;
  localparam logic [31:0] TYPE_HHA = 32'd1;
  localparam logic [31:0] TYPE_L3C = 32'd2;
  localparam logic [31:0] TYPE_PA  = 32'd3;

  localparam int unsigned CFG_IDXW = 3;

  typedef enum logic [CFG_IDXW-1:0] {
    CFG_EN_DDR  = 3'd0,
    CFG_EN_HHA  = 3'd1,
    CFG_EN_L3C  = 3'd2,
    CFG_EN_PA   = 3'd3,
    CFG_TARGET  = 3'd4,
    CFG_BANK    = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_INVALID  = 3'd0,
    ST_DISABLED = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_NEW      = 3'd3,
    ST_UPDATED  = 3'd4,
    ST_DROPPED  = 3'd5,
    ST_WRITTEN  = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SLOT,
    S_RD,
    S_CMP,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [31:0] cluster;
    logic [31:0] etype;
    logic [31:0] code;
  } key_t;

  typedef struct packed {
    key_t        key;
    logic [63:0] tally;
    logic [63:0] first;
    logic [63:0] last;
  } entry_t;

  typedef struct packed {
    status_e     status;
    logic [63:0] count;
    logic [63:0] first;
    logic [63:0] last;
  } res_t;

  typedef struct packed {
    logic          we;
    logic [EAW-1:0] waddr;
    entry_t        wdata;
    logic [EAW-1:0] raddr;
  } ent_ctl_t;

endpackage
`default_nettype wire

// ----- src/fect_ifs.sv -----
// Interfaces: input item, result item and configuration write channels
`default_nettype none
interface fect_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  slot_index;
  logic [63:0] now_time;
  logic [31:0] wr_cluster;
  logic [31:0] wr_event_type;
  logic [31:0] wr_event_code;
  logic        wr_valid;
  modport source (output valid, func, slot_index, now_time, wr_cluster, wr_event_type,
                  wr_event_code, wr_valid, input ready);
  modport sink (input valid, func, slot_index, now_time, wr_cluster, wr_event_type,
                wr_event_code, wr_valid, output ready);
endinterface

interface fect_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] entry_count;
  logic [63:0] entry_first_time;
  logic [63:0] entry_last_time;
  logic [63:0] drop_total;
  modport source (output valid, status, entry_count, entry_first_time, entry_last_time,
                  drop_total, input ready);
  modport sink (input valid, status, entry_count, entry_first_time, entry_last_time,
                drop_total, output ready);
endinterface

interface fect_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- src/fect_slot_mem.sv -----
// Slot table: key memory with registered read, valid bits in flops
`default_nettype none
module fect_slot_mem import fect_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               we_i,
  input  wire logic [SLOT_AW-1:0] waddr_i,
  input  wire key_t               wkey_i,
  input  wire logic               wvalid_i,
  input  wire logic [SLOT_AW-1:0] raddr_i,
  output key_t                    rkey_o,
  output logic                    rvalid_o
);
  key_t                  mem_q [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid_q;
  key_t                  rkey_q;
  logic                  rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wkey_i;
    end
    rkey_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= wvalid_i;
      end
      rvalid_q <= valid_q[raddr_i];
    end
  end

  assign rkey_o   = rkey_q;
  assign rvalid_o = rvalid_q;
endmodule
`default_nettype wire

// ----- src/fect_entry_mem.sv -----
// Count entry memory for both banks, one write and one registered read port
`default_nettype none
module fect_entry_mem import fect_pkg::*; (
  input  wire logic     clk_i,
  input  wire ent_ctl_t ctl_i,
  output entry_t        rdata_o
);
  entry_t mem_q [2*BANK_ENTRIES];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[ctl_i.waddr] <= ctl_i.wdata;
    end
    rdata_q <= mem_q[ctl_i.raddr];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

// ----- src/filtered_event_count_table.sv -----
// Top level: filtered event counter with slot table, linear search over a bank
// Steps: slot writes and out-of-range slots go straight to the output register;
//   events on invalid slots and filtered events pass the slot read first; a counted
//   event then reads and compares one bank entry at a time, up to the bank fill,
//   through one read port of the entry memory feeding a single key comparator.
// Throughput: one item at a time; the next item is taken once the result is
//   parked in the output register. Reset clears slot valid bits, fill counts,
//   drop counter and configuration at once; no clearing pass is needed.
`default_nettype none
module filtered_event_count_table import fect_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fect_in_if.sink     in_i,
  fect_out_if.source  out_o,
  fect_cfg_if.sink    cfg_i
);

  // configuration
  logic [3:0]  en_q;
  logic [31:0] target_q;
  logic        bank_q;

  // control and data registers
  state_e          state_q, state_d;
  logic            func_q;
  logic [63:0]     now_q;
  key_t            key_q, key_d;
  logic [IDXW-1:0] idx_q, idx_d;
  logic [FILLW-1:0] fill_q [2];
  logic [FILLW-1:0] fill_d [2];
  logic [63:0]     drop_q, drop_d;
  res_t            res_q, res_d;
  logic            ovalid_q, ovalid_d;
  res_t            ores_q;
  logic [63:0]     odrop_q;

  // memories
  logic        slot_we;
  key_t        slot_rkey;
  logic        slot_rvalid;
  ent_ctl_t    ent_ctl;
  entry_t      ent_rdata;

  logic        in_fire;
  logic        in_range;
  logic        out_load;
  logic        type_ok;
  logic        cluster_ok;
  logic [EAW-1:0] bank_base;
  logic        key_hit;
  logic        last_idx;
  logic        bank_full;

  assign in_fire  = in_i.valid & in_i.ready;
  assign in_range = {1'b0, in_i.slot_index} < 9'(SLOT_COUNT);
  assign in_i.ready = (state_q == S_IDLE);
  assign out_load = (state_q == S_OUT) && (!ovalid_q || out_o.ready);

  fect_slot_mem u_slot (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (slot_we),
    .waddr_i  (in_i.slot_index[SLOT_AW-1:0]),
    .wkey_i   ('{cluster: in_i.wr_cluster, etype: in_i.wr_event_type,
                 code: in_i.wr_event_code}),
    .wvalid_i (in_i.wr_valid),
    .raddr_i  (in_i.slot_index[SLOT_AW-1:0]),
    .rkey_o   (slot_rkey),
    .rvalid_o (slot_rvalid)
  );

  fect_entry_mem u_entry (
    .clk_i   (clk_i),
    .ctl_i   (ent_ctl),
    .rdata_o (ent_rdata)
  );

  // filter on the slot key as it leaves the slot memory
  always_comb begin
    unique case (slot_rkey.etype)
      TYPE_DDR: type_ok = en_q[0];
      TYPE_HHA: type_ok = en_q[1];
      TYPE_L3C: type_ok = en_q[2];
      TYPE_PA:  type_ok = en_q[3];
      default:  type_ok = 1'b1;
    endcase
  end
  assign cluster_ok = (target_q == ALL_CLUSTERS) || (target_q == slot_rkey.cluster);

  assign bank_base = bank_q ? EAW'(BANK_ENTRIES) : '0;
  assign key_hit   = (ent_rdata.key == key_q);
  assign last_idx  = (FILLW'(idx_q) + FILLW'(1)) == fill_q[bank_q];
  assign bank_full = fill_q[bank_q] == FILLW'(BANK_ENTRIES);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (in_range && !in_i.func) ? S_SLOT : S_OUT;
        end
      end
      S_SLOT: begin
        if (slot_rvalid && type_ok && cluster_ok && fill_q[bank_q] != '0) begin
          state_d = S_RD;
        end else begin
          state_d = S_OUT;
        end
      end
      S_RD:  state_d = S_CMP;
      S_CMP: state_d = (key_hit || last_idx) ? S_OUT : S_RD;
      S_OUT: if (out_load) begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    res_d   = res_q;
    key_d   = key_q;
    idx_d   = idx_q;
    fill_d  = fill_q;
    drop_d  = drop_q;
    slot_we = 1'b0;
    ent_ctl = '{we: 1'b0, waddr: bank_base + EAW'(fill_q[bank_q][IDXW-1:0]),
                wdata: '{key: key_q, tally: 64'd1, first: now_q, last: now_q},
                raddr: bank_base + EAW'(idx_q)};
    unique case (state_q)
      S_IDLE: begin
        res_d = '{status: ST_INVALID, count: '0, first: '0, last: '0};
        if (in_fire && in_range && in_i.func) begin
          slot_we      = 1'b1;
          res_d.status = ST_WRITTEN;
        end
      end
      S_SLOT: begin
        key_d = slot_rkey;
        idx_d = '0;
        if (!slot_rvalid) begin
          res_d.status = ST_INVALID;
        end else if (!type_ok) begin
          res_d.status = ST_DISABLED;
        end else if (!cluster_ok) begin
          res_d.status = ST_MISMATCH;
        end else if (fill_q[bank_q] == '0) begin
          // empty bank: first entry goes in straight away
          ent_ctl.we         = 1'b1;
          ent_ctl.wdata.key  = slot_rkey;
          fill_d[bank_q]     = fill_q[bank_q] + FILLW'(1);
          res_d = '{status: ST_NEW, count: 64'd1, first: now_q, last: now_q};
        end
      end
      S_CMP: begin
        if (key_hit) begin
          ent_ctl.we          = 1'b1;
          ent_ctl.waddr       = bank_base + EAW'(idx_q);
          ent_ctl.wdata       = ent_rdata;
          ent_ctl.wdata.tally = ent_rdata.tally + 64'd1;
          ent_ctl.wdata.last  = now_q;
          res_d = '{status: ST_UPDATED, count: ent_rdata.tally + 64'd1,
                    first: ent_rdata.first, last: now_q};
        end else if (last_idx) begin
          if (bank_full) begin
            drop_d       = drop_q + 64'd1;
            res_d.status = ST_DROPPED;
          end else begin
            ent_ctl.we     = 1'b1;
            fill_d[bank_q] = fill_q[bank_q] + FILLW'(1);
            res_d = '{status: ST_NEW, count: 64'd1, first: now_q, last: now_q};
          end
        end else begin
          idx_d = idx_q + IDXW'(1);
        end
      end
      default: ;
    endcase
  end

  assign ovalid_d = out_load ? 1'b1 : (out_o.ready ? 1'b0 : ovalid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      en_q      <= 4'hF;
      target_q  <= ALL_CLUSTERS;
      bank_q    <= 1'b0;
      fill_q[0] <= '0;
      fill_q[1] <= '0;
      drop_q    <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      drop_q   <= drop_d;
      ovalid_q <= ovalid_d;
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          CFG_EN_DDR: en_q[0]  <= cfg_i.data[0];
          CFG_EN_HHA: en_q[1]  <= cfg_i.data[0];
          CFG_EN_L3C: en_q[2]  <= cfg_i.data[0];
          CFG_EN_PA:  en_q[3]  <= cfg_i.data[0];
          CFG_TARGET: target_q <= cfg_i.data;
          CFG_BANK:   bank_q   <= cfg_i.data[0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q <= in_i.func;
      now_q  <= in_i.now_time;
    end
    key_q <= key_d;
    idx_q <= idx_d;
    res_q <= res_d;
    if (out_load) begin
      ores_q  <= res_q;
      odrop_q <= drop_q;
    end
  end

  assign cfg_i.ready            = 1'b1;
  assign out_o.valid            = ovalid_q;
  assign out_o.status           = ores_q.status;
  assign out_o.entry_count      = ores_q.count;
  assign out_o.entry_first_time = ores_q.first;
  assign out_o.entry_last_time  = ores_q.last;
  assign out_o.drop_total       = odrop_q;

  // checks
  a_fill0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q[0] <= FILLW'(BANK_ENTRIES)) else $error("bank 0 fill overrun");
  a_fill1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q[1] <= FILLW'(BANK_ENTRIES)) else $error("bank 1 fill overrun");
  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP && drop_d != drop_q) |-> (bank_full && !key_hit))
    else $error("drop counted with room in bank");
  a_entwr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ent_ctl.we |-> (state_q == S_SLOT || state_q == S_CMP))
    else $error("entry write outside search");
  a_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SLOT) |-> !func_q)
    else $error("slot lookup for a write item");

endmodule
`default_nettype wire
